@@ sv/unsigned_decimal_formatter_defines.svh @@
// Assertion macros shared by the unsigned decimal formatter modules.
`ifndef UNSIGNED_DECIMAL_FORMATTER_DEFINES_SVH
`define UNSIGNED_DECIMAL_FORMATTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define UDF_ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udf: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define UDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udf: next-cycle check failed");

`endif

@@ sv/udf_pkg.sv @@
// Types, constants and helper functions of the unsigned decimal formatter.
package udf_pkg;

    // Input beat layout.
    localparam int VALUE_W  = 64;
    localparam int FWIDTH_W = 6;
    localparam int PREC_W   = 7;
    localparam int MODE_W   = 2;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    // Decimal conversion: twenty BCD digits, four binary bits per cycle.
    localparam int DIGITS        = 20;
    localparam int BCD_W         = 4 * DIGITS;
    localparam int DIG_CNT_W     = 5;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = 4;

    // Adjust modes.
    localparam logic [MODE_W-1:0] ADJ_RIGHT = 2'd0;
    localparam logic [MODE_W-1:0] ADJ_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] ADJ_ZERO  = 2'd2;
    localparam logic [MODE_W-1:0] ADJ_ALT   = 2'd3;

    // Characters.
    localparam logic [7:0] ASCII_SPACE = 8'h20;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic shift;
        logic measure;
        logic plan;
        logic emit;
    } t_udf_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic last;
        logic can_load;
    } t_udf_sts;

    // One add-3 correction over all BCD digits ahead of a left shift.
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] >= 4'd5) begin
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    // Number of significant decimal digits; a zero value still has one.
    function automatic logic [DIG_CNT_W-1:0] lead_digits(input logic [BCD_W-1:0] bcd);
        logic [DIG_CNT_W-1:0] n;
        n = DIG_CNT_W'(1);
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[4*i +: 4] != 4'd0) begin
                n = DIG_CNT_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/udf_ctrl.sv @@
// Sequencing controller of the unsigned decimal formatter.
`include "unsigned_decimal_formatter_defines.svh"

module udf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  udf_pkg::t_udf_sts i_sts,
    output udf_pkg::t_udf_cmd o_cmd
);
    import udf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_MEASURE,
        ST_PLAN,
        ST_EMIT
    } t_state;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CONV_STEPS - 1);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    // A new beat is taken only between items.
    assign o_s_tready = (r_state == ST_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.shift = 1'b1;
                n_step      = r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = ST_MEASURE;
                end
            end
            ST_MEASURE: begin
                o_cmd.measure = 1'b1;
                n_state       = ST_PLAN;
            end
            ST_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.empty) begin
                    n_state = ST_IDLE;
                end else if (i_sts.can_load) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // A character goes out only into a free output stage and only when one is left.
    `UDF_ASSERT_HOLDS(a_emit_gated, i_clk, i_rst_n, o_cmd.emit, i_sts.can_load && !i_sts.empty)
    // The final character of a text ends the item.
    `UDF_ASSERT_NEXT(a_last_ends_item, i_clk, i_rst_n, o_cmd.emit && i_sts.last, r_state == ST_IDLE)

endmodule

@@ sv/udf_datapath.sv @@
// Conversion, field planning and character output of the unsigned decimal formatter.
`include "unsigned_decimal_formatter_defines.svh"

module udf_datapath #(
    parameter int MAX_FIELD = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [udf_pkg::VALUE_W-1:0]    i_value,
    input  logic [udf_pkg::FWIDTH_W-1:0]   i_field_width,
    input  logic [udf_pkg::PREC_W-1:0]     i_min_digits,
    input  logic [udf_pkg::MODE_W-1:0]     i_adjust_mode,
    input  udf_pkg::t_udf_cmd              i_cmd,
    output udf_pkg::t_udf_sts              o_sts,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [udf_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                           o_m_tlast
);
    import udf_pkg::*;

    localparam int CW = $clog2(MAX_FIELD + 1);
    localparam int TW = CW + 2;
    localparam logic [PREC_W-1:0] MAX_WIDE = PREC_W'(MAX_FIELD);
    localparam logic [CW-1:0]     MAX_CW   = CW'(MAX_FIELD);

    // Captured item.
    logic [VALUE_W-1:0]   r_bin;
    logic [BCD_W-1:0]     r_bcd;
    logic [CW-1:0]        r_width;
    logic [CW-1:0]        r_prec;
    logic                 r_prec_set;
    logic [MODE_W-1:0]    r_mode;
    logic [DIG_CNT_W-1:0] r_len_raw;
    logic                 r_is_zero;

    // Segment counters, in output order.
    logic [CW-1:0]        r_lead;
    logic [CW-1:0]        r_zeros;
    logic [DIG_CNT_W-1:0] r_ndig;
    logic [CW-1:0]        r_trail;

    // Output stage.
    logic                 r_out_valid;
    logic [7:0]           r_out_char;
    logic                 r_out_last;

    logic [BCD_W-1:0]     n_bcd;
    logic [VALUE_W-1:0]   n_bin;
    logic [PREC_W-1:0]    width_wide;
    logic [PREC_W-1:0]    prec_wide;
    logic [DIG_CNT_W-1:0] plan_len;
    logic [CW-1:0]        len_cw;
    logic [CW-1:0]        body;
    logic [CW-1:0]        spaces;
    logic [TW-1:0]        total;
    logic                 can_load;
    logic [DIG_CNT_W-1:0] dig_idx;
    logic [3:0]           dig_val;
    logic [7:0]           next_char;

    // Four shift-and-correct steps of the binary to BCD conversion.
    always_comb begin
        n_bcd = r_bcd;
        n_bin = r_bin;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            n_bcd = dabble(n_bcd);
            n_bcd = {n_bcd[BCD_W-2:0], n_bin[VALUE_W-1]};
            n_bin = {n_bin[VALUE_W-2:0], 1'b0};
        end
    end

    // Saturation of the requested width and precision.
    assign width_wide = {1'b0, i_field_width};
    assign prec_wide  = {1'b0, i_min_digits[PREC_W-2:0]};

    // Field plan: digits, zero fill up to the body length, then spaces up to the width.
    always_comb begin
        plan_len = (r_is_zero && r_prec_set && (r_prec == '0)) ? '0 : r_len_raw;
        len_cw   = CW'(plan_len);
        if (r_prec_set) begin
            body = (r_prec > len_cw) ? r_prec : len_cw;
        end else if ((r_mode == ADJ_ZERO) && (r_width > len_cw)) begin
            body = r_width;
        end else begin
            body = len_cw;
        end
        spaces = (r_width > body) ? (r_width - body) : '0;
    end

    // Characters still to go, and the next one.
    assign total    = TW'(r_lead) + TW'(r_zeros) + TW'(r_ndig) + TW'(r_trail);
    assign can_load = !r_out_valid || i_m_tready;
    assign dig_idx  = r_ndig - DIG_CNT_W'(1);
    assign dig_val  = r_bcd[{dig_idx, 2'b00} +: 4];

    always_comb begin
        if (r_lead != '0) begin
            next_char = ASCII_SPACE;
        end else if (r_zeros != '0) begin
            next_char = ASCII_ZERO;
        end else if (r_ndig != '0) begin
            next_char = ASCII_ZERO + {4'd0, dig_val};
        end else begin
            next_char = ASCII_SPACE;
        end
    end

    assign o_sts.empty    = (total == '0);
    assign o_sts.last     = (total == TW'(1));
    assign o_sts.can_load = can_load;

    // Item capture and conversion registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin      <= i_value;
            r_bcd      <= '0;
            r_width    <= (width_wide > MAX_WIDE) ? MAX_CW : CW'(width_wide);
            r_prec_set <= !i_min_digits[PREC_W-1];
            if (i_min_digits[PREC_W-1]) begin
                r_prec <= '0;
            end else begin
                r_prec <= (prec_wide > MAX_WIDE) ? MAX_CW : CW'(prec_wide);
            end
            r_mode     <= (i_adjust_mode == ADJ_ALT) ? ADJ_RIGHT : i_adjust_mode;
        end else if (i_cmd.shift) begin
            r_bin <= n_bin;
            r_bcd <= n_bcd;
        end
        if (i_cmd.measure) begin
            r_len_raw <= lead_digits(r_bcd);
            r_is_zero <= (r_bcd == '0);
        end
    end

    // Segment counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_zeros <= '0;
            r_ndig  <= '0;
            r_trail <= '0;
        end else if (i_cmd.plan) begin
            r_lead  <= (r_mode == ADJ_LEFT) ? '0 : spaces;
            r_zeros <= body - len_cw;
            r_ndig  <= plan_len;
            r_trail <= (r_mode == ADJ_LEFT) ? spaces : '0;
        end else if (i_cmd.emit) begin
            if (r_lead != '0) begin
                r_lead <= r_lead - CW'(1);
            end else if (r_zeros != '0) begin
                r_zeros <= r_zeros - CW'(1);
            end else if (r_ndig != '0) begin
                r_ndig <= r_ndig - DIG_CNT_W'(1);
            end else begin
                r_trail <= r_trail - CW'(1);
            end
        end
    end

    // Output register: a beat waits here while the next character is prepared.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_char <= next_char;
            r_out_last <= (total == TW'(1));
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

    // The planned text never runs past the saturated field size.
    `UDF_ASSERT_HOLDS(a_text_bound, i_clk, i_rst_n, 1'b1, total <= TW'(MAX_FIELD))
    // Sending the last character leaves nothing behind.
    `UDF_ASSERT_NEXT(a_last_drains, i_clk, i_rst_n, i_cmd.emit && o_sts.last, total == '0)

endmodule

@@ sv/unsigned_decimal_formatter.sv @@
// Top level of the unsigned decimal formatter.
// Formats one unsigned 64-bit value per input beat as printf-style decimal text and
// sends it out one ASCII character per beat, tlast on the final character; an empty
// text sends nothing. An item passes through acceptance, binary to BCD conversion at
// four bits per cycle in the shift-and-add-3 unit, a digit count, padding planning,
// then one character per cycle from the output register while the output side is
// ready; a new value is taken only once the previous item is done. Width and precision
// saturate at MAX_FIELD, so at most MAX_FIELD characters leave per item.
module unsigned_decimal_formatter #(
    parameter int MAX_FIELD = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // value[63:0], field_width[69:64], min_digits[76:70], adjust_mode[78:77], zero[79]
    input  logic [udf_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // char_out[7:0]
    output logic [udf_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);
    import udf_pkg::*;

    t_udf_cmd cmd;
    t_udf_sts sts;

    // Sequencer.
    udf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Conversion and output datapath.
    udf_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (i_s_tdata[VALUE_W-1:0]),
        .i_field_width (i_s_tdata[VALUE_W +: FWIDTH_W]),
        .i_min_digits  (i_s_tdata[VALUE_W+FWIDTH_W +: PREC_W]),
        .i_adjust_mode (i_s_tdata[VALUE_W+FWIDTH_W+PREC_W +: MODE_W]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

endmodule

@@ verif/unsigned_decimal_formatter_test.sv @@
// Self-checking testbench for the unsigned decimal formatter: directed and random values.
module unsigned_decimal_formatter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import udf_pkg::*;

    localparam int          FIELD_MAX   = 32;
    localparam logic [6:0]  NO_PREC     = 7'h7F;
    localparam int          TAIL_CYCLES = 40;
    localparam int          DRAIN_LIMIT = 30000;
    localparam int          PHASE_ITEMS = 112;
    localparam longint      LIMIT_NS    = 64'd20_000_000;

    // One formatting request; typed rows carry their expected text.
    typedef struct {
        logic [63:0] val;
        logic [5:0]  fw;
        logic [6:0]  pr;
        logic [1:0]  md;
        bit          typed;
        string       text;
    } t_fmt_req;

    // One expected output beat.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    t_fmt_req   cur_req;
    t_fmt_req   dir_reqs[$];
    t_char_beat pending_chars[$];
    int         err_cnt = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    unsigned_decimal_formatter #(
        .MAX_FIELD(FIELD_MAX)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata),
        .o_m_tlast (m_tlast)
    );

    // Clock with a 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard limit on the run time.
    initial begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Receiver back-pressure, rolled once per cycle.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Formats a request the way printf does for an unsigned decimal conversion.
    function automatic string format_decimal(input t_fmt_req rq);
        int          width, prec, ndig, zeros, spaces;
        bit          has_prec;
        logic [1:0]  mode;
        logic [63:0] rest;
        logic [7:0]  digits[20];
        string       text;
        width    = (int'(rq.fw) > FIELD_MAX) ? FIELD_MAX : int'(rq.fw);
        has_prec = !rq.pr[6];
        prec     = has_prec ? int'(rq.pr) : 0;
        if (prec > FIELD_MAX) begin
            prec = FIELD_MAX;
        end
        mode = (rq.md == ADJ_ALT) ? ADJ_RIGHT : rq.md;

        // Digits, least significant first.
        rest = rq.val;
        ndig = 0;
        do begin
            digits[ndig] = ASCII_ZERO + 8'(rest % 64'd10);
            ndig++;
            rest = rest / 64'd10;
        end while (rest != 0);
        if (rq.val == 0 && has_prec && prec == 0) begin
            ndig = 0;
        end

        // Zero padding comes from the precision, or from the width in zero mode.
        zeros = (has_prec && prec > ndig) ? prec - ndig : 0;
        if (mode == ADJ_ZERO && !has_prec && width > ndig) begin
            zeros = width - ndig;
        end
        spaces = (width > ndig + zeros) ? width - ndig - zeros : 0;

        text = "";
        if (mode != ADJ_LEFT) begin
            repeat (spaces) text = $sformatf("%s%c", text, ASCII_SPACE);
        end
        repeat (zeros) text = $sformatf("%s%c", text, ASCII_ZERO);
        for (int i = ndig - 1; i >= 0; i--) begin
            text = $sformatf("%s%c", text, digits[i]);
        end
        if (mode == ADJ_LEFT) begin
            repeat (spaces) text = $sformatf("%s%c", text, ASCII_SPACE);
        end
        return text;
    endfunction

    // Queues the characters of one text, marking the final one.
    function automatic void queue_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            pending_chars.push_back('{text[i], i == text.len() - 1});
        end
    endfunction

    function automatic void report_mismatch(input string what, input logic [7:0] want,
                                            input logic [7:0] got);
        if (err_cnt < 10) begin
            $display("%0t: %s mismatch: expected 0x%02h, got 0x%02h", $time, what, want, got);
        end
        err_cnt++;
    endfunction

    // Scoreboard: check output beats first, then record the accepted request.
    always @(posedge i_clk) begin : scoreboard
        t_char_beat want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected beat", 8'h00, m_tdata);
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch) begin
                    report_mismatch("character", want.ch, m_tdata);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("tlast", 8'(want.last), 8'(m_tlast));
                end
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            queue_text(cur_req.typed ? cur_req.text : format_decimal(cur_req));
        end
    end

    // Random request, weighted toward digit-count boundaries and padding cases.
    function automatic t_fmt_req random_req();
        t_fmt_req    rq;
        logic [63:0] pow;
        int          k;
        rq.typed = 1'b0;
        rq.text  = "";
        case ($urandom_range(0, 5))
            0: rq.val = 64'($urandom_range(0, 99));
            1: rq.val = {$urandom, $urandom};
            2: begin
                pow = 64'd1;
                k   = $urandom_range(0, 19);
                repeat (k) pow = pow * 64'd10;
                rq.val = pow + 64'($urandom_range(0, 2)) - 64'd1;
            end
            3: rq.val = {$urandom, $urandom} >> $urandom_range(1, 63);
            4: rq.val = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 15));
            default: rq.val = '0;
        endcase
        rq.fw = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 34));
        case ($urandom_range(0, 5))
            0, 1:    rq.pr = NO_PREC;
            2, 3, 4: rq.pr = 7'($urandom_range(0, 34));
            default: rq.pr = 7'($urandom_range(0, 127));
        endcase
        rq.md = 2'($urandom_range(0, 3));
        return rq;
    endfunction

    // Drives one request; returns at the falling edge after its beat was taken.
    task automatic send_req(input t_fmt_req rq);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        cur_req = rq;
        s_tdata  <= {1'b0, rq.md, rq.pr, rq.fw, rq.val};
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected character has come out.
    task automatic wait_for_text();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // Main sequence: reset, directed table, then four idling phases.
    initial begin
        dir_reqs = '{
            '{64'd0, 6'd0, NO_PREC, ADJ_RIGHT, 1'b1, "0"},
            '{64'd0, 6'd0, 7'd0, ADJ_RIGHT, 1'b1, ""},
            '{64'd0, 6'd5, 7'd0, ADJ_RIGHT, 1'b1, "     "},
            '{64'd0, 6'd5, 7'd0, ADJ_LEFT, 1'b1, "     "},
            '{64'hFFFF_FFFF_FFFF_FFFF, 6'd0, NO_PREC, ADJ_RIGHT, 1'b1,
              "18446744073709551615"},
            '{64'hFFFF_FFFF_FFFF_FFFF, 6'd32, NO_PREC, ADJ_ZERO, 1'b1,
              "00000000000018446744073709551615"},
            '{64'hFFFF_FFFF_FFFF_FFFF, 6'd63, NO_PREC, ADJ_LEFT, 1'b0, ""},
            '{64'd42, 6'd5, NO_PREC, ADJ_RIGHT, 1'b1, "   42"},
            '{64'd42, 6'd5, NO_PREC, ADJ_LEFT, 1'b1, "42   "},
            '{64'd42, 6'd5, NO_PREC, ADJ_ZERO, 1'b1, "00042"},
            '{64'd42, 6'd6, 7'd4, ADJ_ZERO, 1'b1, "  0042"},
            '{64'd42, 6'd6, NO_PREC, ADJ_ALT, 1'b0, ""},
            '{64'd7, 6'd4, 7'h7B, ADJ_ZERO, 1'b1, "0007"},
            '{64'd7, 6'd63, 7'h3F, ADJ_RIGHT, 1'b0, ""},
            '{64'd0, 6'd63, NO_PREC, ADJ_ZERO, 1'b0, ""},
            '{64'd123, 6'd0, 7'd32, ADJ_LEFT, 1'b0, ""},
            '{64'd9999999999999999999, 6'd0, NO_PREC, ADJ_RIGHT, 1'b0, ""},
            '{64'd10000000000000000000, 6'd21, NO_PREC, ADJ_ZERO, 1'b0, ""},
            '{64'd0, 6'd0, 7'h40, ADJ_ZERO, 1'b0, ""},
            '{64'd1, 6'd1, 7'd1, ADJ_LEFT, 1'b1, "1"},
            '{64'd0, 6'd3, 7'd0, ADJ_ZERO, 1'b1, "   "},
            '{64'd0, 6'd0, 7'd0, ADJ_LEFT, 1'b1, ""},
            '{64'd5, 6'd32, 7'd32, ADJ_ALT, 1'b0, ""}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_reqs[i]) begin
            send_req(dir_reqs[i]);
        end
        wait_for_text();

        // Idling phases: none, sender gaps, receiver stalls, then both.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 88 : (phase == 3) ? 30 : 0;
            recv_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 30 : 0;
            repeat (PHASE_ITEMS) send_req(random_req());
            wait_for_text();
        end

        err_cnt += pending_chars.size();
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
